// ===== design/terminal_escape_input_decoder_defines.svh =====
// Assertion macros for the terminal escape input decoder
`ifndef TERMINAL_ESCAPE_INPUT_DECODER_DEFINES_SVH
`define TERMINAL_ESCAPE_INPUT_DECODER_DEFINES_SVH
`ifndef SYNTHESIS
`define TEID_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("assertion failed");
`define TEID_ASSERT_NORST(label, clk, prop) \
	label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define TEID_ASSERT(label, clk, rst_n, prop)
`define TEID_ASSERT_NORST(label, clk, prop)
`endif
`endif

// ===== design/teid_pkg.sv =====
// Package: shared types and constants of the terminal escape input decoder
`timescale 1ns / 1ps
`default_nettype none
package teid_pkg;
	localparam logic [8:0] K_UP      = 9'd256;
	localparam logic [8:0] K_HOME    = 9'd260;
	localparam logic [8:0] K_END     = 9'd261;
	localparam logic [8:0] K_PGUP    = 9'd262;
	localparam logic [8:0] K_PGDN    = 9'd263;
	localparam logic [8:0] K_F5      = 9'd264;
	localparam logic [8:0] K_ESCAPE  = 9'd265;
	localparam logic [8:0] K_UNKNOWN = 9'd266;

	localparam logic [2:0] EV_KEY     = 3'd0;
	localparam logic [2:0] EV_PRESS   = 3'd1;
	localparam logic [2:0] EV_RELEASE = 3'd2;
	localparam logic [2:0] EV_SCROLL  = 3'd3;
	localparam logic [2:0] EV_DOUBLE  = 3'd4;

	localparam logic [1:0] REG_DCLICK = 2'd0;
	localparam logic [1:0] REG_SCROLL = 2'd1;
	localparam logic [1:0] REG_SLACK  = 2'd2;

	localparam int EVENT_W = 55;

	typedef struct packed {
		logic [15:0] mouse_row;
		logic [15:0] mouse_column;
		logic [7:0]  button_code;
		logic [2:0]  modifier_bits;
		logic [8:0]  key_value;
		logic [2:0]  event_kind;
	} event_t;

	function automatic event_t key_event(input logic [8:0] key, input logic [2:0] mods);
		event_t e;
		e = '0;
		e.event_kind = EV_KEY;
		e.key_value = key;
		e.modifier_bits = mods;
		return e;
	endfunction

	function automatic logic [8:0] arrow_key(input logic [7:0] c);
		logic [8:0] k;
		case (c)
			8'h41: k = K_UP;
			8'h42: k = K_UP + 9'd1;
			8'h43: k = K_UP + 9'd2;
			8'h44: k = K_UP + 9'd3;
			default: k = K_UNKNOWN;
		endcase
		return k;
	endfunction
endpackage
`default_nettype wire

// ===== design/terminal_escape_input_decoder.sv =====
// Top level: terminal escape input decoder, stream in, stream out
// Throughput: one input word per cycle while the skid register is empty (s_tready high);
// the state update for each byte is one pass of logic, and results go to the output register.
// A skid register holds a result when the output stalls so input continues one more word.
// Reset (arst_n low) returns the parser to idle, clears click and scroll history and
// loads the register defaults 400, 150 and 1.
`timescale 1ns / 1ps
`default_nettype none
`include "terminal_escape_input_decoder_defines.svh"
module terminal_escape_input_decoder #(
	parameter int MAX_SEQUENCE_BYTES = 31
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,  // byte_value[7:0], now_ms[39:8]
	input  wire logic        s_tuser,  // action
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [55:0]      m_tdata,  // event_kind, key_value, modifier_bits, button_code,
	                                    // mouse_column, mouse_row, zero fill
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);
	localparam int LW = $clog2(MAX_SEQUENCE_BYTES + 1);
	typedef enum logic [2:0] {PH_IDLE, PH_ESC, PH_SEQ, PH_U1, PH_U2} phase_t;

	phase_t phase_q;
	logic [LW-1:0] len_q;
	logic [7:0] kc_q [3];
	logic [1:0] kcnt_q;
	logic [15:0] mf_q [3];
	logic [1:0] mfi_q;
	logic [1:0] mfl_q [3];
	logic [7:0] u1_q;
	logic [31:0] sc_time_q; logic [7:0] sc_btn_q; logic sc_valid_q;
	logic [31:0] ck_time_q; logic [15:0] ck_col_q, ck_row_q; logic [7:0] ck_btn_q;
	logic ck_valid_q;
	logic [15:0] dclick_q, sdeb_q; logic [7:0] slack_q;

	// output register plus skid
	teid_pkg::event_t out_q, skid_q;
	logic out_v_q, skid_v_q;

	logic acc, gap;
	logic [7:0] b;
	logic [31:0] now;
	assign s_tready = !skid_v_q;
	assign acc = s_tvalid && s_tready;
	assign gap = s_tuser;
	assign b = gap ? 8'd0 : s_tdata[7:0];
	assign now = s_tdata[39:8];

	// sequence collection next values
	logic [LW-1:0] len_n;
	logic [7:0] kc_n [3];
	logic [1:0] kcnt_n, mfi_n;
	logic [15:0] mf_n [3];
	logic [1:0] mfl_n [3];
	logic [19:0] prod;
	logic [1:0] fl;
	always_comb begin
		len_n = len_q + LW'(1);
		kc_n = kc_q; kcnt_n = kcnt_q; mf_n = mf_q; mfl_n = mfl_q; mfi_n = mfi_q;
		prod = '0; fl = '0;
		if (b != 8'h3B && kcnt_q != 2'd3) begin
			kc_n[kcnt_q] = b;
			kcnt_n = kcnt_q + 2'd1;
		end
		if (b == 8'h3B) begin
			if (mfi_q != 2'd3 && mfl_q[mfi_q][0]) mfi_n = mfi_q + 2'd1;
		end else if (mfi_q != 2'd3) begin
			fl = mfl_q[mfi_q];
			if (!fl[0] && mfi_q == 2'd0 && b == 8'h3C) begin
				mfl_n[0] = 2'b01;
			end else begin
				fl[0] = 1'b1;
				if (!fl[1]) begin
					if (b >= 8'h30 && b <= 8'h39) begin
						prod = {mf_q[mfi_q], 3'b0} + {3'b0, mf_q[mfi_q], 1'b0}
							+ 20'(b - 8'h30);
						mf_n[mfi_q] = (prod > 20'd65535) ? 16'hFFFF : prod[15:0];
					end else begin
						fl[1] = 1'b1;
					end
				end
				mfl_n[mfi_q] = fl;
			end
		end
	end

	teid_pkg::event_t key_gap_ev, key_take_ev;
	teid_key_decode u_kd_gap (.count(kcnt_q), .c0(kc_q[0]), .c1(kc_q[1]), .c2(kc_q[2]),
		.ev(key_gap_ev));
	teid_key_decode u_kd_take (.count(kcnt_n), .c0(kc_n[0]), .c1(kc_n[1]), .c2(kc_n[2]),
		.ev(key_take_ev));

	// mouse decode on updated fields
	logic [1:0] mcount;
	logic [7:0] btn;
	logic [15:0] dx;
	logic [31:0] dt_s, dt_c;
	logic term_letter, is_mouse, upper_m, sc_rep, dbl;
	always_comb begin
		mcount = mfi_n;
		if (mfi_n != 2'd3 && mfl_n[mfi_n][0]) mcount = mfi_n + 2'd1;
		btn = (mf_n[0] > 16'd255) ? 8'hFF : mf_n[0][7:0];
		dx = (mf_n[1] > ck_col_q) ? mf_n[1] - ck_col_q : ck_col_q - mf_n[1];
		dt_s = now - sc_time_q;
		dt_c = now - ck_time_q;
		term_letter = (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A) || b == 8'h7E;
		upper_m = b == 8'h4D;
		is_mouse = upper_m || b == 8'h6D;
		sc_rep = sc_valid_q && dt_s < {16'd0, sdeb_q} && sc_btn_q == btn;
		dbl = ck_valid_q && dt_c < {16'd0, dclick_q} && dx <= {8'd0, slack_q}
			&& mf_n[2] == ck_row_q && btn == ck_btn_q;
	end

	teid_pkg::event_t res;
	logic res_v;
	phase_t phase_n;
	logic clr, take, sc_upd, ck_upd, ck_clr;
	always_comb begin
		res = teid_pkg::key_event(teid_pkg::K_UNKNOWN, 3'd0);
		res_v = 1'b0; phase_n = phase_q; clr = 1'b0; take = 1'b0;
		sc_upd = 1'b0; ck_upd = 1'b0; ck_clr = 1'b0;
		case (phase_q)
			PH_ESC: begin
				phase_n = PH_IDLE;
				if (b == 8'd0) begin
					res_v = 1'b1; res = teid_pkg::key_event(teid_pkg::K_ESCAPE, 3'd0);
				end else if (b == 8'h5B || b == 8'h4F) begin
					clr = 1'b1; phase_n = PH_SEQ;
				end else begin
					res_v = 1'b1;
				end
			end
			PH_SEQ: begin
				if (b == 8'd0) begin
					phase_n = PH_IDLE; res_v = 1'b1; res = key_gap_ev;
				end else begin
					take = 1'b1;
					if (term_letter || {1'b0, len_n} >= (LW+1)'(MAX_SEQUENCE_BYTES)) begin
						phase_n = PH_IDLE; res_v = 1'b1; res = key_take_ev;
						if (term_letter && is_mouse && mcount == 2'd3) begin
							res.button_code = btn;
							res.mouse_column = mf_n[1];
							res.mouse_row = mf_n[2];
							res.event_kind = teid_pkg::EV_RELEASE;
							res.key_value = teid_pkg::K_UNKNOWN;
							res.modifier_bits = 3'd0;
							if (btn >= 8'd64) begin
								if (upper_m && !sc_rep) begin
									res.event_kind = teid_pkg::EV_SCROLL; sc_upd = 1'b1;
								end
							end else if (upper_m) begin
								if (dbl) begin
									res.event_kind = teid_pkg::EV_DOUBLE; ck_clr = 1'b1;
								end else begin
									res.event_kind = teid_pkg::EV_PRESS; ck_upd = 1'b1;
								end
							end
						end else if (term_letter && is_mouse) begin
							res = teid_pkg::key_event(teid_pkg::K_UNKNOWN, 3'd0);
						end
					end
				end
			end
			PH_U1: phase_n = PH_U2;
			PH_U2: begin
				phase_n = PH_IDLE; res_v = 1'b1;
				if (u1_q == 8'hBD && b == 8'h9E) res = teid_pkg::key_event(9'h07E, 3'd0);
			end
			default: begin
				phase_n = PH_IDLE;
				if (!gap) begin
					if (b == 8'h1B) phase_n = PH_ESC;
					else if (b == 8'hEF) phase_n = PH_U1;
					else begin
						res_v = 1'b1; res = teid_pkg::key_event({1'b0, b}, 3'd0);
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE; len_q <= '0; kcnt_q <= '0; mfi_q <= '0; u1_q <= '0;
			for (int i = 0; i < 3; i++) begin
				kc_q[i] <= '0; mf_q[i] <= '0; mfl_q[i] <= '0;
			end
			sc_time_q <= '0; sc_btn_q <= '0; sc_valid_q <= 1'b0;
			ck_time_q <= '0; ck_col_q <= '0; ck_row_q <= '0; ck_btn_q <= '0;
			ck_valid_q <= 1'b0;
			dclick_q <= 16'd400; sdeb_q <= 16'd150; slack_q <= 8'd1;
			out_v_q <= 1'b0; skid_v_q <= 1'b0;
			out_q <= '0; skid_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					teid_pkg::REG_DCLICK: dclick_q <= cfg_data;
					teid_pkg::REG_SCROLL: sdeb_q <= cfg_data;
					teid_pkg::REG_SLACK: slack_q <= cfg_data[7:0];
					default: ;
				endcase
			end
			if (acc) begin
				phase_q <= phase_n;
				if (phase_q == PH_U1) u1_q <= b;
				if (clr) begin
					len_q <= '0; kcnt_q <= '0; mfi_q <= '0;
					for (int i = 0; i < 3; i++) begin
						kc_q[i] <= '0; mf_q[i] <= '0; mfl_q[i] <= '0;
					end
				end else if (take) begin
					len_q <= len_n; kcnt_q <= kcnt_n; mfi_q <= mfi_n;
					kc_q <= kc_n; mf_q <= mf_n; mfl_q <= mfl_n;
				end
				if (sc_upd) begin
					sc_time_q <= now; sc_btn_q <= btn; sc_valid_q <= 1'b1;
				end
				if (ck_upd) begin
					ck_time_q <= now; ck_col_q <= mf_n[1]; ck_row_q <= mf_n[2];
					ck_btn_q <= btn; ck_valid_q <= 1'b1;
				end
				if (ck_clr) ck_valid_q <= 1'b0;
			end
			// output register and skid
			if (!out_v_q || m_tready) begin
				if (skid_v_q) begin
					out_v_q <= 1'b1; out_q <= skid_q; skid_v_q <= 1'b0;
				end else begin
					out_v_q <= acc && res_v; out_q <= res;
				end
			end else if (acc && res_v) begin
				skid_v_q <= 1'b1; skid_q <= res;
			end
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata = {1'b0, out_q};

	`TEID_ASSERT(a_skid_only_stalled, clk, arst_n, skid_v_q |-> out_v_q)
	`TEID_ASSERT(a_stall_holds, clk, arst_n, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
	`TEID_ASSERT(a_seq_bounded, clk, arst_n, {1'b0, len_q} <= (LW+1)'(MAX_SEQUENCE_BYTES))
	`TEID_ASSERT(a_dbl_clears, clk, arst_n, (acc && ck_clr) |=> !ck_valid_q)
endmodule
`default_nettype wire

// ===== design/teid_key_decode.sv =====
// Key sequence decode from the first three collected bytes
`timescale 1ns / 1ps
`default_nettype none
module teid_key_decode (
	input  wire logic [1:0] count,
	input  wire logic [7:0] c0,
	input  wire logic [7:0] c1,
	input  wire logic [7:0] c2,
	output teid_pkg::event_t ev
);
	logic [8:0] key;
	logic [2:0] mods;
	always_comb begin
		key = teid_pkg::K_UNKNOWN;
		mods = 3'd0;
		if (count == 2'd1) begin
			if (c0 == 8'h48) key = teid_pkg::K_HOME;
			else if (c0 == 8'h46) key = teid_pkg::K_END;
			else key = teid_pkg::arrow_key(c0);
		end else if (count == 2'd2 && c0 == 8'h35 && c1 == 8'h7E) begin
			key = teid_pkg::K_PGUP;
		end else if (count == 2'd2 && c0 == 8'h36 && c1 == 8'h7E) begin
			key = teid_pkg::K_PGDN;
		end else if (count == 2'd3 && c0 == 8'h31 && c1 == 8'h35 && c2 == 8'h7E) begin
			key = teid_pkg::K_F5;
		end else if (count == 2'd3 && c2 >= 8'h41 && c2 <= 8'h44) begin
			key = teid_pkg::arrow_key(c2);
			if (c1 >= 8'h32 && c1 <= 8'h38) mods = 3'(c1 - 8'h31);
		end
		ev = teid_pkg::key_event(key, mods);
	end
endmodule
`default_nettype wire
